// ===== design/bba_pkg.sv =====
package bba_pkg;

  localparam int IDX_W         = 8;
  localparam int CNT_W         = 9;
  localparam int IDX_RANGE     = 1 << IDX_W;
  localparam int BITS_PER_BYTE = 8;
  localparam int WORD_W        = 32;
  localparam int WORD_LB       = 5;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REINIT  = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_count;
  } cfg_t;

endpackage

// ===== design/bba_chan_if.sv =====
interface bba_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/bitmap_block_allocator.sv =====
// Bitmap block allocator: one used bit per block plus a free-block counter.
// Channels: cmd (command, block_index) in, rsp (granted_index, status,
// free_count) out, cfg (block_count) for the device size. All are
// valid/ready; a transfer happens when both are high at a clock edge.
// One command is worked at a time. Query, reinitialize and out-of-range
// release go from idle straight to the done state; a release first reads its
// map word in the release state; a reserve reads W 32-bit map words in the
// scan state before a free block is found (W at most the larger of 1 and
// ceil(count/32), 8 for 256 blocks). The map RAM is read one word per cycle
// and the search walks the words in order.
// The result sits in an output register, so the next command is taken while
// it waits; a stalled receiver holds back only the completion of that next
// command. Reset, a cfg write and a reinitialize clear the map at once
// (per-word valid bits) with the map's own blocks reading as used; reset and
// cfg writes then hold cmd ready low while the free count is recomputed. cfg
// is always ready; write it only while idle, the block does not enforce this.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 512
) (
  input logic       clk,
  input logic       rst,
  bba_chan_if.sink   cmd,
  bba_chan_if.source rsp,
  bba_chan_if.sink   cfg
);
  localparam int MAP_BITS = MAX_BLOCKS < bba_pkg::IDX_RANGE ? MAX_BLOCKS : bba_pkg::IDX_RANGE;
  localparam int WORDS    = (MAP_BITS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int AW       = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int PB       = bba_pkg::BITS_PER_BYTE * BLOCK_BYTES;
  localparam int MAPB_MAX = (MAP_BITS + PB - 1) / PB;
  localparam int MBW      = $clog2(MAPB_MAX + 1);
  localparam int WW       = bba_pkg::WORD_W;
  localparam int LB       = bba_pkg::WORD_LB;
  localparam int CW       = bba_pkg::CNT_W;

  bba_pkg::state_t state, state_next;
  logic [CW-1:0]   block_count;
  logic            pend, pend_next;
  logic [CW-1:0]   free, free_next;
  logic [WORDS-1:0] wvalid, wvalid_next;
  logic [AW-1:0]   ptr, ptr_next;
  logic [LB-1:0]   rel_bit, rel_bit_next;
  bba_pkg::rsp_t   res, res_next, out;
  logic            out_valid;
  logic            load;

  logic [CW-1:0]   eff;
  logic [MBW-1:0]  mapb;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [WW-1:0]   wdata, rd_q, word;
  logic [WW-1:0]   avail;
  logic            found;
  logic [LB-1:0]   found_bit;
  logic            last;

  function automatic logic [WW-1:0] init_word(input logic [AW-1:0] p,
                                              input logic [MBW-1:0] mb);
    logic [WW-1:0] w;
    w = '0;
    for (int b = 0; b < WW; b++) begin
      w[b] = 10'({p, LB'(b)}) < 10'(mb);
    end
    return w;
  endfunction

  bba_ram #(.WIDTH(WW), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_q)
  );

  assign eff = (block_count > CW'(MAP_BITS)) ? CW'(MAP_BITS) : block_count;

  always_comb begin
    mapb = '0;
    for (int i = 0; i < MAPB_MAX; i++) begin
      if (32'(eff) > i * PB) begin
        mapb = MBW'(i + 1);
      end
    end
  end

  assign word = wvalid[ptr] ? rd_q : init_word(ptr, mapb);

  always_comb begin
    for (int b = 0; b < WW; b++) begin
      avail[b] = !word[b] && (10'({ptr, LB'(b)}) < 10'(eff));
    end
    found     = 1'b0;
    found_bit = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found     = 1'b1;
        found_bit = LB'(b);
      end
    end
  end

  assign last = (10'({ptr, LB'(0)}) + 10'(WW) >= 10'(eff)) || (ptr == AW'(WORDS - 1));

  assign cmd.ready = (state == bba_pkg::ST_IDLE) && !pend;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bba_pkg::ST_IDLE;
      block_count <= CW'(256);
      pend        <= 1'b1;
      free        <= '0;
      wvalid      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      free   <= free_next;
      wvalid <= wvalid_next;
      if (cfg.valid && cfg.ready) begin
        block_count <= cfg.data.block_count;
        pend        <= 1'b1;
      end else begin
        pend <= pend_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    rel_bit <= rel_bit_next;
    res     <= res_next;
    if (load) begin
      out <= res;
    end
  end

  always_comb begin
    state_next   = state;
    pend_next    = pend;
    free_next    = free;
    wvalid_next  = wvalid;
    ptr_next     = ptr;
    rel_bit_next = rel_bit;
    res_next     = res;
    raddr        = ptr;
    we           = 1'b0;
    waddr        = ptr;
    wdata        = word;
    load         = 1'b0;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (pend) begin
          wvalid_next = '0;
          free_next   = eff - CW'(mapb);
          pend_next   = 1'b0;
        end else if (cmd.valid) begin
          res_next.granted_index = '0;
          res_next.status        = bba_pkg::STAT_OK;
          res_next.free_count    = free;
          state_next             = bba_pkg::ST_DONE;
          unique case (cmd.data.command)
            bba_pkg::CMD_RESERVE: begin
              ptr_next   = '0;
              raddr      = '0;
              state_next = bba_pkg::ST_SCAN;
            end
            bba_pkg::CMD_RELEASE: begin
              if (CW'(cmd.data.block_index) >= eff) begin
                res_next.status = bba_pkg::STAT_RANGE;
              end else begin
                ptr_next     = AW'(cmd.data.block_index >> LB);
                raddr        = AW'(cmd.data.block_index >> LB);
                rel_bit_next = cmd.data.block_index[LB-1:0];
                state_next   = bba_pkg::ST_REL;
              end
            end
            bba_pkg::CMD_REINIT: begin
              wvalid_next         = '0;
              free_next           = eff - CW'(mapb);
              res_next.free_count = eff - CW'(mapb);
            end
            bba_pkg::CMD_QUERY: begin
            end
          endcase
        end
      end
      bba_pkg::ST_SCAN: begin
        if (found) begin
          we                     = 1'b1;
          wdata                  = word | (WW'(1) << found_bit);
          wvalid_next[ptr]       = 1'b1;
          free_next              = free - CW'(free != '0);
          res_next.granted_index = 8'({ptr, found_bit});
          res_next.free_count    = free - CW'(free != '0);
          state_next             = bba_pkg::ST_DONE;
        end else if (last) begin
          res_next.status = bba_pkg::STAT_NO_SPACE;
          state_next      = bba_pkg::ST_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
          raddr    = ptr + AW'(1);
        end
      end
      bba_pkg::ST_REL: begin
        if (word[rel_bit]) begin
          we                  = 1'b1;
          wdata               = word & ~(WW'(1) << rel_bit);
          wvalid_next[ptr]    = 1'b1;
          free_next           = free + CW'(free < eff);
          res_next.free_count = free + CW'(free < eff);
        end
        state_next = bba_pkg::ST_DONE;
      end
      bba_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    !pend |-> free <= eff)
    else $error("free count above block count");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == bba_pkg::ST_SCAN || state == bba_pkg::ST_REL))
    else $error("map write outside scan or release");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> state != bba_pkg::ST_IDLE)
    else $error("command transfer did not start work");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::ST_DONE && (!out_valid || rsp.ready)) |=> out_valid)
    else $error("result not presented");
endmodule

// ===== verif/bitmap_block_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;

  localparam int MAX_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;

  bba_chan_if #(.T(bba_pkg::req_t)) cmd_ch ();
  bba_chan_if #(.T(bba_pkg::rsp_t)) rsp_ch ();
  bba_chan_if #(.T(bba_pkg::cfg_t)) cfg_ch ();

  bitmap_block_allocator #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // allocator shadow state
  logic [MAX_BLOCKS-1:0]         used_bits;
  logic [bba_pkg::CNT_W-1:0]     free_left;
  logic [bba_pkg::CNT_W-1:0]     dev_blocks;

  bba_pkg::req_t pending_cmds[$];
  bba_pkg::rsp_t predicted_rsp[$];
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          burst_left;
  int          gap_left;
  int          ready_mode;
  int          mode_left;
  int          hold_left;
  int          holds_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned live_blocks();
    return (dev_blocks > MAX_BLOCKS) ? MAX_BLOCKS : dev_blocks;
  endfunction

  function automatic void rebuild_map();
    int unsigned n;
    int unsigned per_blk;
    int unsigned meta;
    n       = live_blocks();
    per_blk = bba_pkg::BITS_PER_BYTE * BLOCK_BYTES;
    meta    = (n + per_blk - 1) / per_blk;
    if (meta > n) meta = n;
    used_bits = '0;
    for (int unsigned i = 0; i < meta; i++) used_bits[i] = 1'b1;
    free_left = bba_pkg::CNT_W'(n - meta);
  endfunction

  function automatic bba_pkg::rsp_t apply_command(bba_pkg::req_t r);
    bba_pkg::rsp_t res;
    int unsigned n;
    bit          found;
    n     = live_blocks();
    res   = '0;
    found = 1'b0;
    res.status = bba_pkg::STAT_OK;
    case (bba_pkg::cmd_t'(r.command))
      bba_pkg::CMD_RESERVE: begin
        for (int unsigned i = 0; i < n && !found; i++) begin
          if (!used_bits[i]) begin
            used_bits[i] = 1'b1;
            if (free_left != 0) free_left--;
            res.granted_index = i[bba_pkg::IDX_W-1:0];
            found = 1'b1;
          end
        end
        if (!found) res.status = bba_pkg::STAT_NO_SPACE;
      end
      bba_pkg::CMD_RELEASE: begin
        if (r.block_index >= n) begin
          res.status = bba_pkg::STAT_RANGE;
        end else if (used_bits[r.block_index]) begin
          used_bits[r.block_index] = 1'b0;
          if (free_left < n) free_left++;
        end
      end
      bba_pkg::CMD_REINIT: rebuild_map();
      default: ;
    endcase
    res.free_count = free_left;
    return res;
  endfunction

  // driver: bursts from the pending queue, shadow state follows each transfer
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
      dev_blocks = 9'd256;
      rebuild_map();
      burst_left = $urandom_range(1, 30);
      gap_left   = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        dev_blocks = cfg_ch.data.block_count;
        rebuild_map();
      end
      if (cmd_ch.valid && cmd_ch.ready) predicted_rsp.push_back(apply_command(cmd_ch.data));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data  <= pending_cmds.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each transfer, stall on a shifting pattern
  always @(posedge clk) begin
    bba_pkg::rsp_t exp_r;
    bba_pkg::rsp_t got_r;
    bit   ready_now;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_mode = 0;
      mode_left  = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_r = rsp_ch.data;
        results_seen <= results_seen + 1;
        if (predicted_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: granted %0d status %0d free %0d",
                     got_r.granted_index, got_r.status, got_r.free_count);
        end else begin
          exp_r = predicted_rsp.pop_front();
          if (got_r.granted_index != exp_r.granted_index || got_r.status != exp_r.status ||
              got_r.free_count != exp_r.free_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result %0d: exp granted %0d status %0d free %0d, got %0d %0d %0d",
                       results_seen, exp_r.granted_index, exp_r.status, exp_r.free_count,
                       got_r.granted_index, got_r.status, got_r.free_count);
          end
        end
      end
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (ready_mode)
        0:       ready_now = 1'b1;
        1:       ready_now = ($urandom_range(0, 3) != 0);
        2:       ready_now = ($urandom_range(0, 9) < 3);
        default: ready_now = (cycles % 4) != 3;
      endcase
      rsp_ch.ready <= ready_now && (hold_left == 0);
    end
  end

  // long receiver hold-off so the block backs up into the command channel
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_seen >= 300 * (holds_done + 1)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_cmd(bba_pkg::cmd_t c, int unsigned idx);
    bba_pkg::req_t r;
    r.command     = c;
    r.block_index = idx[bba_pkg::IDX_W-1:0];
    pending_cmds.push_back(r);
  endtask

  task automatic add_random(int n, int pct_res, int pct_rel, int unsigned blocks);
    int unsigned roll;
    int unsigned top;
    int unsigned idx;
    top = (blocks > MAX_BLOCKS) ? MAX_BLOCKS - 1 : blocks - 1;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      idx  = $urandom_range(0, 255);
      if (roll < pct_res) begin
        push_cmd(bba_pkg::CMD_RESERVE, idx);
      end else if (roll < pct_res + pct_rel) begin
        if (blocks != 0 && $urandom_range(0, 4) != 0) idx = $urandom_range(0, top);
        push_cmd(bba_pkg::CMD_RELEASE, idx);
      end else if (roll < pct_res + pct_rel + 5) begin
        push_cmd(bba_pkg::CMD_REINIT, idx);
      end else begin
        push_cmd(bba_pkg::CMD_QUERY, idx);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || predicted_rsp.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_blocks(int unsigned v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v[bba_pkg::CNT_W-1:0];
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full device from reset: map block, release of map and free blocks
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RELEASE, 0);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RELEASE, 5);
    push_cmd(bba_pkg::CMD_RELEASE, 255);
    push_cmd(bba_pkg::CMD_RELEASE, 2);
    push_cmd(bba_pkg::CMD_QUERY, 0);
    push_cmd(bba_pkg::CMD_REINIT, 0);
    push_cmd(bba_pkg::CMD_QUERY, 0);
    add_random(250, 40, 35, 256);
    drain();

    write_blocks(9);
    push_cmd(bba_pkg::CMD_RELEASE, 9);
    push_cmd(bba_pkg::CMD_RELEASE, 8);
    push_cmd(bba_pkg::CMD_RELEASE, 128);
    add_random(120, 45, 40, 9);
    drain();

    // empty device
    write_blocks(0);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RELEASE, 0);
    push_cmd(bba_pkg::CMD_RELEASE, 255);
    push_cmd(bba_pkg::CMD_REINIT, 0);
    push_cmd(bba_pkg::CMD_QUERY, 0);
    add_random(20, 40, 35, 0);
    drain();

    // single block, taken by the map
    write_blocks(1);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RELEASE, 0);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    push_cmd(bba_pkg::CMD_RESERVE, 0);
    add_random(40, 45, 40, 1);
    drain();

    write_blocks(300);
    add_random(120, 55, 25, 256);
    drain();

    // saturated count, reserve heavy to run out of space
    write_blocks(511);
    add_random(300, 90, 8, 256);
    drain();

    write_blocks(2);
    add_random(50, 45, 40, 2);
    drain();

    write_blocks(37);
    add_random(140, 50, 35, 37);
    drain();

    write_blocks(256);
    add_random(60, 40, 35, 256);
    drain();

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bba_pkg.sv
design/bba_chan_if.sv
design/bba_ram.sv
design/bitmap_block_allocator.sv
verif/bitmap_block_allocator_tb.sv
